// File: rtl/deq_pkg.sv
package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-transaction command broadcast to every cell of the row.
    typedef struct packed {
        logic shift_to_back;
        logic shift_to_front;
        logic load_tail;
    } t_cell_ctrl;

endpackage

// File: rtl/deq_cell.sv
module deq_cell import deq_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [CW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_prev,
    input  logic [DATA_WIDTH-1:0] i_next,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  is_tail;

    // The tail slot is the first unoccupied cell, at index equal to the count.
    assign is_tail = (i_count == CW'(INDEX));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_to_back) begin
            r_data <= i_prev;
        end else if (i_ctrl.shift_to_front) begin
            r_data <= i_next;
        end else if (i_ctrl.load_tail && is_tail) begin
            r_data <= i_value;
        end
    end

    assign o_data = r_data;

endmodule

// File: rtl/double_ended_queue_top.sv
// Bounded double-ended queue of DATA_WIDTH-bit words, DEPTH entries deep.
// Input channel: i_in_valid / o_in_stall carry i_operation and i_value
// (push back, push front, pop front, pop back, reverse). Output channel:
// o_out_valid / i_out_stall carry the front and back values, the count, an
// empty flag and a status for every input transaction, in order.
// Storage is a row of cells with the physical front always in cell 0: a push
// or pop at the physical front shifts the whole row by one cell, a push at
// the physical back loads the cell at the tail. Reverse only toggles a flag
// that swaps which physical end is the logical front.
// The state update is registered at acceptance, and the result is then formed
// from the row into the output register. One transaction per cycle is
// sustained while the receiver does not stall.
// When the receiver stalls, the result holds in the output register and
// one further transaction is still taken; then o_in_stall rises until the
// output register frees. A full push or an empty pop changes nothing and
// reports status 1 or 2. Reset empties the queue, clears the reverse flag
// and drops any pending result; stored words are not cleared.
module double_ended_queue_top import deq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_operation,
    input  logic [DATA_WIDTH-1:0]        i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [DATA_WIDTH-1:0]        o_front_value,
    output logic [DATA_WIDTH-1:0]        o_back_value,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic                         o_is_empty,
    output logic [1:0]                   o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    logic [CW-1:0]         r_count, n_count;
    logic                  r_rev, n_rev;
    t_status               r_status, n_status;
    logic                  r_pend;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_front, r_back;
    logic [CW-1:0]         r_out_count;
    t_status               r_out_status;

    t_op                   op;
    t_cell_ctrl            ctrl, cell_ctrl;
    logic                  in_accept;
    logic                  out_load;
    logic                  is_full, is_empty;
    logic                  at_phys_end;
    logic [CW-1:0]         count_m1;
    logic [AW-1:0]         tail_idx;
    logic [DATA_WIDTH-1:0] phys_front, phys_back;

    assign out_load   = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !(!r_out_valid || !i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        op          = t_op'(i_operation);
        ctrl        = '0;
        n_count     = r_count;
        n_rev       = r_rev;
        n_status    = ST_DONE;
        at_phys_end = 1'b0;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    at_phys_end = (op == OP_PUSH_BACK) != r_rev;
                    if (at_phys_end) begin
                        ctrl.load_tail = 1'b1;
                    end else begin
                        ctrl.shift_to_back = 1'b1;
                    end
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    at_phys_end = (op == OP_POP_FRONT) != r_rev;
                    // Popping the physical front moves every entry one cell down;
                    // popping the physical back only shortens the count.
                    if (at_phys_end) begin
                        ctrl.shift_to_front = 1'b1;
                    end
                    n_count = r_count - CW'(1);
                end
            end
            OP_REVERSE: begin
                n_rev = !r_rev;
            end
            default: begin
            end
        endcase
        cell_ctrl = in_accept ? ctrl : '0;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] prev_data, next_data;
            if (g == 0) begin : g_first
                assign prev_data = i_value;
            end else begin : g_mid
                assign prev_data = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign next_data = cell_data[g];
            end else begin : g_inner
                assign next_data = cell_data[g+1];
            end
            deq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CW         (CW),
                .INDEX      (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (cell_ctrl),
                .i_count (r_count),
                .i_value (i_value),
                .i_prev  (prev_data),
                .i_next  (next_data),
                .o_data  (cell_data[g])
            );
        end
    endgenerate

    assign count_m1   = r_count - CW'(1);
    assign tail_idx   = count_m1[AW-1:0];
    assign phys_front = is_empty ? '0 : cell_data[0];
    assign phys_back  = is_empty ? '0 : cell_data[tail_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_count <= n_count;
                r_rev   <= n_rev;
            end
            if (in_accept) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status <= n_status;
        end
        if (out_load) begin
            r_front      <= r_rev ? phys_back : phys_front;
            r_back       <= r_rev ? phys_front : phys_back;
            r_out_count  <= r_count;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_count       = r_out_count;
    assign o_is_empty    = (r_out_count == '0);
    assign o_status      = r_out_status;

endmodule

// File: rtl/deq_checker.sv
module deq_checker import deq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic [DATA_WIDTH-1:0]      i_front_value,
    input logic [DATA_WIDTH-1:0]      i_back_value,
    input logic [$clog2(DEPTH+1)-1:0] i_count,
    input logic                       i_is_empty,
    input logic [1:0]                 i_status
);

    localparam int CW = $clog2(DEPTH + 1);

    // The reported count never exceeds the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_count <= CW'(DEPTH)))
        else $error("count above capacity");

    // An empty queue reports zero at both ends.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_empty) |-> (i_front_value == '0 && i_back_value == '0))
        else $error("empty queue with nonzero end values");

    // A single entry is both front and back.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_count == CW'(1)) |-> (i_front_value == i_back_value))
        else $error("single entry with different ends");

    // A refused push only happens at capacity.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_FULL) |-> (i_count == CW'(DEPTH)))
        else $error("push refused below capacity");

    // A refused pop only happens on an empty queue.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_EMPTY) |-> i_is_empty)
        else $error("pop refused on a nonempty queue");

endmodule

bind double_ended_queue_top deq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_front_value (o_front_value),
    .i_back_value  (o_back_value),
    .i_count       (o_count),
    .i_is_empty    (o_is_empty),
    .i_status      (o_status)
);
